// ===== hw/rtl/sact_pkg.sv =====
// Shared types and constants of the cache tag store.
package sact_pkg;
    localparam int SETS        = 256;
    localparam int WAYS        = 4;
    localparam int OFFSET_BITS = 6;
    localparam int ADDR_BITS   = 32;
    localparam int IB          = $clog2(SETS);
    localparam int BLK_BITS    = ADDR_BITS - OFFSET_BITS;
    localparam int TAG_BITS    = BLK_BITS - IB;
    localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AGE_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_BITS    = (IB > 0) ? IB : 1;
    localparam int LINE_BITS   = TAG_BITS + 1 + 1 + AGE_BITS;
    localparam int ROW_BITS    = LINE_BITS * WAYS;
    localparam int CLR_BITS    = SET_BITS + 1;

    typedef enum logic [1:0] {
        CMD_READ = 2'd0, CMD_WRITE = 2'd1, CMD_FILL = 2'd2, CMD_WBACK = 2'd3
    } t_cmd;

    localparam logic [0:0] REG_WB_MODE = 1'b0;

    typedef struct packed {
        logic capture;
        logic clear;
        logic update;
        logic load;
    } t_ctrl;
endpackage

// ===== hw/rtl/sact_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface sact_req_if;
    import sact_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] address;
    logic        mark_dirty;
    modport source (output valid, command, address, mark_dirty, input ready);
    modport sink   (input valid, command, address, mark_dirty, output ready);
endinterface

interface sact_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic        eviction;
    logic        victim_dirty;
    logic [25:0] evicted_block;
    modport source (output valid, hit, eviction, victim_dirty, evicted_block, input ready);
    modport sink   (input valid, hit, eviction, victim_dirty, evicted_block, output ready);
endinterface

// ===== hw/rtl/set_assoc_lru_cache_tags.sv =====
// Top level of the set-associative LRU cache tag store.
// Each request reads its set from the tag RAM, then makes the hit/victim decision and
// writes the row back; one result per request, held until taken, and the next request is
// accepted in the cycle the result leaves. After reset a clearing pass sweeps every set of
// the tag RAM before the first request is taken. write_back_mode lies at address 0.
module set_assoc_lru_cache_tags import sact_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sact_req_if.sink    req,
    sact_rsp_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_ctrl w_ctrl;
    logic [CLR_BITS-1:0] w_clr;
    logic r_wb_mode;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_WB_MODE) ? {31'd0, r_wb_mode} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_wb_mode <= 1'b1;
        else if (psel && penable && pwrite && paddr == REG_WB_MODE) r_wb_mode <= pwdata[0];
    end

    sact_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(req.valid), .o_in_ready(req.ready),
        .o_out_valid(rsp.valid), .i_out_ready(rsp.ready), .o_ctrl(w_ctrl), .o_clr_idx(w_clr)
    );

    sact_datapath u_dp (
        .i_clk(i_clk), .i_ctrl(w_ctrl), .i_clr_idx(w_clr), .i_wb_mode(r_wb_mode),
        .i_command(req.command), .i_address(req.address), .i_mark_dirty(req.mark_dirty),
        .o_hit(rsp.hit), .o_eviction(rsp.eviction), .o_victim_dirty(rsp.victim_dirty),
        .o_evicted_block(rsp.evicted_block)
    );
endmodule

// ===== hw/rtl/sact_ram.sv =====
// Generic single-port RAM with registered read.
module sact_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== hw/rtl/sact_datapath.sv =====
// Set lookup, LRU update and victim selection datapath.
module sact_datapath import sact_pkg::*; (
    input  logic                i_clk,
    input  t_ctrl               i_ctrl,
    input  logic [CLR_BITS-1:0] i_clr_idx,
    input  logic                i_wb_mode,
    input  logic [1:0]          i_command,
    input  logic [31:0]         i_address,
    input  logic                i_mark_dirty,
    output logic                o_hit,
    output logic                o_eviction,
    output logic                o_victim_dirty,
    output logic [25:0]         o_evicted_block
);
    logic [1:0]          r_cmd;
    logic                r_mk;
    logic [TAG_BITS-1:0] r_tag;
    logic [SET_BITS-1:0] r_set;
    logic [BLK_BITS-1:0] w_blk;
    logic [SET_BITS-1:0] w_addr;
    logic                w_we;
    logic [ROW_BITS-1:0] w_rd, w_wr;

    always_comb begin
        if (i_command == CMD_WBACK) w_blk = i_address[BLK_BITS-1:0];
        else w_blk = i_address[ADDR_BITS-1:OFFSET_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_cmd <= i_command;
            r_mk  <= i_mark_dirty;
            r_tag <= w_blk[BLK_BITS-1:IB];
            if (IB > 0) r_set <= w_blk[SET_BITS-1:0];
            else r_set <= '0;
        end
    end

    always_comb begin
        if (i_ctrl.clear) w_addr = i_clr_idx[SET_BITS-1:0];
        else if (i_ctrl.capture) w_addr = (IB > 0) ? w_blk[SET_BITS-1:0] : '0;
        else w_addr = r_set;
    end
    assign w_we = i_ctrl.clear | i_ctrl.update;

    sact_ram #(.WIDTH(ROW_BITS), .DEPTH(1 << SET_BITS)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
        .i_wdata(i_ctrl.clear ? '0 : w_wr), .o_rdata(w_rd)
    );

    // line layout: {tag, valid, dirty, age}
    logic [TAG_BITS-1:0] w_t [WAYS];
    logic                w_v [WAYS];
    logic                w_d [WAYS];
    logic [AGE_BITS-1:0] w_a [WAYS];
    logic                w_found, w_inv_found, w_is_inst, w_dirty_new;
    logic [WAY_BITS-1:0] w_way, w_inv, w_lru, w_sel;
    logic [AGE_BITS:0]   w_old;
    logic                w_ev;

    always_comb begin
        w_found = 1'b0; w_way = '0; w_inv_found = 1'b0; w_inv = '0; w_lru = '0;
        for (int w = 0; w < WAYS; w++) begin
            {w_t[w], w_v[w], w_d[w], w_a[w]} = w_rd[w*LINE_BITS +: LINE_BITS];
        end
        for (int w = WAYS-1; w >= 0; w--) begin
            if (w_v[w] && w_t[w] == r_tag) begin
                w_found = 1'b1; w_way = WAY_BITS'(w);
            end
            if (!w_v[w]) begin
                w_inv_found = 1'b1; w_inv = WAY_BITS'(w);
            end
        end
        for (int w = 1; w < WAYS; w++) begin
            if (w_a[w] > w_a[w_lru]) w_lru = WAY_BITS'(w);
        end
        w_is_inst = !w_found && r_cmd[1];
        w_sel = w_found ? w_way : (w_inv_found ? w_inv : w_lru);
        w_ev  = w_is_inst && w_v[w_sel];
        w_old = w_v[w_sel] ? {1'b0, w_a[w_sel]} : (AGE_BITS+1)'(WAYS);
        w_dirty_new = i_wb_mode && (r_cmd == CMD_WBACK || r_cmd == CMD_WRITE ||
                      (r_cmd == CMD_FILL && r_mk));
        w_wr = w_rd;
        if (w_found || w_is_inst) begin
            for (int w = 0; w < WAYS; w++) begin
                if (WAY_BITS'(w) != w_sel && w_v[w] && {1'b0, w_a[w]} < w_old)
                    w_wr[w*LINE_BITS +: AGE_BITS] = w_a[w] + 1'b1;
            end
            w_wr[w_sel*LINE_BITS +: LINE_BITS] = {
                w_is_inst ? r_tag : w_t[w_sel], 1'b1,
                w_is_inst ? w_dirty_new : (w_d[w_sel] | w_dirty_new),
                AGE_BITS'(0)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            o_hit            <= w_found;
            o_eviction       <= w_ev;
            o_victim_dirty   <= w_ev && i_wb_mode && w_d[w_sel];
            o_evicted_block  <= w_ev ? 26'({w_t[w_sel], r_set[IB > 0 ? IB-1 : 0:0]}) : '0;
        end
    end
endmodule

// ===== hw/rtl/sact_ctrl.sv =====
// Controller sequencing clear pass, lookup and result hand-off.
module sact_ctrl import sact_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_ctrl               o_ctrl,
    output logic [CLR_BITS-1:0] o_clr_idx
);
    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK, S_OUT} t_state;
    t_state r_state;
    logic [CLR_BITS-1:0] r_clr;

    assign o_in_ready = (r_state == S_IDLE) || (r_state == S_OUT && i_out_ready);
    assign o_clr_idx  = r_clr;
    always_comb begin
        o_ctrl.clear   = r_state == S_CLEAR;
        o_ctrl.capture = i_in_valid && o_in_ready;
        o_ctrl.update  = r_state == S_LOOK;
        o_ctrl.load    = r_state == S_LOOK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_clr <= '0; o_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CLR_BITS'((1 << SET_BITS) - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (i_in_valid) r_state <= S_LOOK;
                S_LOOK: begin
                    r_state <= S_OUT; o_out_valid <= 1'b1;
                end
                S_OUT: if (i_out_ready) begin
                    o_out_valid <= 1'b0;
                    r_state <= i_in_valid ? S_LOOK : S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== bench/sact_checker.sv =====
// Request/result monitor with a cache tag store predictor and result comparison.
module sact_checker import sact_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sact_req_if         req,
    sact_rsp_if         rsp,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [0:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fails,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        hit;
        logic        eviction;
        logic        victim_dirty;
        logic [25:0] evicted_block;
    } t_lookup;

    localparam int LINES = SETS * WAYS;

    bit                  line_ok [LINES];
    bit                  line_dty[LINES];
    logic [TAG_BITS-1:0] line_tg [LINES];
    int                  line_rank[LINES];
    bit                  wb_mode;
    t_lookup             lookups_due[$];

    // Make one way most recent; ranks younger than its old rank grow older.
    function automatic void promote(int base, int way);
        int old;
        old = line_ok[base + way] ? line_rank[base + way] : WAYS;
        for (int w = 0; w < WAYS; w++)
            if (w != way && line_ok[base + w] && line_rank[base + w] < old)
                line_rank[base + w]++;
        line_rank[base + way] = 0;
    endfunction

    function automatic t_lookup lookup(t_cmd cmd, logic [31:0] addr, logic mk);
        t_lookup             r;
        logic [BLK_BITS-1:0] blk;
        logic [IB-1:0]       set;
        logic [TAG_BITS-1:0] tg;
        int                  base, way, vic, li;
        bit                  found;
        r = '0;
        blk = (cmd == CMD_WBACK) ? addr[BLK_BITS-1:0] : addr[31:OFFSET_BITS];
        set = blk[IB-1:0];
        tg = blk[BLK_BITS-1:IB];
        base = int'(set) * WAYS;
        found = 0;
        way = 0;
        for (int w = 0; w < WAYS; w++)
            if (!found && line_ok[base + w] && line_tg[base + w] == tg) begin
                found = 1;
                way = w;
            end
        if (found) begin
            promote(base, way);
            if (wb_mode && (cmd == CMD_WRITE || cmd == CMD_WBACK || (cmd == CMD_FILL && mk)))
                line_dty[base + way] = 1;
        end else if (cmd == CMD_FILL || cmd == CMD_WBACK) begin
            vic = -1;
            for (int w = 0; w < WAYS; w++)
                if (vic < 0 && !line_ok[base + w]) vic = w;
            if (vic < 0) begin
                vic = 0;
                for (int w = 1; w < WAYS; w++)
                    if (line_rank[base + w] > line_rank[base + vic]) vic = w;
            end
            li = base + vic;
            if (line_ok[li]) begin
                r.eviction = 1;
                r.evicted_block = {line_tg[li], set};
                r.victim_dirty = wb_mode && line_dty[li];
            end
            promote(base, vic);
            line_ok[li] = 1;
            line_tg[li] = tg;
            line_dty[li] = wb_mode && (cmd == CMD_WBACK || mk);
        end
        r.hit = found;
        return r;
    endfunction

    assign o_pending = lookups_due.size();

    always @(posedge i_clk) begin
        t_lookup e;
        if (!i_rst_n) begin
            for (int i = 0; i < LINES; i++) begin
                line_ok[i] = 0;
                line_dty[i] = 0;
                line_tg[i] = '0;
                line_rank[i] = 0;
            end
            wb_mode = 1;
            lookups_due.delete();
            o_fails <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == REG_WB_MODE)
                wb_mode = i_pwdata[0];
            if (req.valid && req.ready)
                lookups_due.push_back(lookup(t_cmd'(req.command), req.address,
                                             req.mark_dirty));
            if (rsp.valid && rsp.ready) begin
                if (lookups_due.size() == 0) begin
                    $error("result with no request outstanding");
                    o_fails <= o_fails + 1;
                end else begin
                    e = lookups_due.pop_front();
                    if (rsp.hit !== e.hit || rsp.eviction !== e.eviction ||
                        rsp.victim_dirty !== e.victim_dirty ||
                        rsp.evicted_block !== e.evicted_block)
                        o_fails <= o_fails + 1;
                    if (rsp.hit !== e.hit)
                        $error("hit: expected %0d got %0d", e.hit, rsp.hit);
                    if (rsp.eviction !== e.eviction)
                        $error("eviction: expected %0d got %0d", e.eviction, rsp.eviction);
                    if (rsp.victim_dirty !== e.victim_dirty)
                        $error("victim_dirty: expected %0d got %0d",
                               e.victim_dirty, rsp.victim_dirty);
                    if (rsp.evicted_block !== e.evicted_block)
                        $error("evicted_block: expected %h got %h",
                               e.evicted_block, rsp.evicted_block);
                end
            end
        end
    end
endmodule

// ===== bench/tb_set_assoc_lru_cache_tags.sv =====
// Testbench top: clock, reset, request and register stimulus, verdict.
module tb_set_assoc_lru_cache_tags;
    import sact_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 5000;

    logic        i_clk = 0;
    logic        i_rst_n;
    logic        psel, penable, pwrite, pready;
    logic [0:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          fails, pending;
    int          phase = 0;
    bit          hold_req = 0;
    int          idle_cnt = 0;

    sact_req_if req_ch();
    sact_rsp_if rsp_ch();

    set_assoc_lru_cache_tags u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(req_ch), .rsp(rsp_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    sact_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(req_ch), .rsp(rsp_ch),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_fails(fails), .o_pending(pending)
    );

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    // Abort when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: random stalls in phases 2 and 3, and one long hold-off on request.
    initial begin
        rsp_ch.ready <= 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                rsp_ch.ready <= 0;
                repeat (300) @(posedge i_clk);
            end
            if (phase == 2)
                rsp_ch.ready <= ($urandom_range(0, 99) >= 88);
            else if (phase == 3)
                rsp_ch.ready <= ($urandom_range(0, 99) >= 22);
            else
                rsp_ch.ready <= 1;
        end
    end

    task automatic send(t_cmd cmd, logic [31:0] addr, logic mk);
        int pct;
        pct = (phase == 1) ? 88 : (phase == 3) ? 22 : 0;
        if (pct > 0 && $urandom_range(0, 99) < pct) begin
            req_ch.valid <= 0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < pct) @(posedge i_clk);
        end
        req_ch.valid <= 1;
        req_ch.command <= cmd;
        req_ch.address <= addr;
        req_ch.mark_dirty <= mk;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic reg_write(logic [0:0] idx, logic [31:0] val);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= idx;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0;
        penable <= 0;
    endtask

    // Wait for every outstanding result, then a little more.
    task automatic drain();
        req_ch.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Addresses crowd a few sets and tags so hits and evictions are common.
    task automatic send_random();
        t_cmd        cmd;
        logic [17:0] tg;
        logic [7:0]  set;
        logic [31:0] addr;
        cmd = t_cmd'($urandom_range(0, 3));
        tg = ($urandom_range(0, 9) == 0) ? 18'(18'h3FFFF - $urandom_range(0, 2))
                                         : 18'($urandom_range(0, 6));
        set = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0)
            addr = $urandom;
        else if (cmd == CMD_WBACK)
            addr = {6'($urandom), tg, set};
        else
            addr = {tg, set, 6'($urandom)};
        send(cmd, addr, 1'($urandom));
    endtask

    initial begin
        bit mode;
        i_rst_n <= 0;
        req_ch.valid <= 0;
        req_ch.command <= CMD_READ;
        req_ch.address <= '0;
        req_ch.mark_dirty <= 0;
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        paddr <= REG_WB_MODE;
        pwdata <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: misses, installs into empty ways, LRU eviction, hits, extremes.
        send(CMD_READ, 32'h0, 0);
        send(CMD_WRITE, 32'hFFFF_FFFF, 1);
        send(CMD_FILL, 32'h0000_0000, 1);
        send(CMD_FILL, 32'h0000_4000, 0);
        send(CMD_WBACK, 32'h0000_0200, 0);
        send(CMD_FILL, 32'h0000_C03F, 0);
        send(CMD_READ, 32'h0000_0000, 0);
        send(CMD_WRITE, 32'h0000_4000, 0);
        send(CMD_FILL, 32'h0001_0000, 0);
        send(CMD_WBACK, 32'hFFFF_FF00, 0);
        send(CMD_FILL, 32'h0000_0000, 1);
        send(CMD_FILL, 32'hFFFF_FFFF, 1);
        send(CMD_WBACK, 32'hFFFF_FFFF, 0);
        send(CMD_WBACK, 32'h03FF_FFFF, 0);
        send(CMD_FILL, 32'hFFFF_C000, 0);
        send(CMD_FILL, 32'hFFFF_8000, 1);
        send(CMD_FILL, 32'hFFFF_4000, 0);
        send(CMD_READ, 32'hFFFF_FFC0, 0);
        send(CMD_WRITE, 32'hFFFF_8000, 0);
        send(CMD_FILL, 32'h0002_0000, 0);
        send(CMD_FILL, 32'h0003_0000, 0);
        drain();

        for (int p = 0; p < 4; p++) begin
            phase = 0;
            mode = p[0] ? 0 : 1;
            if (p == 3) mode = 0;
            reg_write(REG_WB_MODE, {31'($urandom), mode});
            phase = p;
            if (p == 0) hold_req = 1;
            repeat (108) send_random();
            drain();
        end
        reg_write(REG_WB_MODE, 32'h1);
        phase = 0;
        repeat (4) send_random();
        drain();

        if (fails == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
